/* sv/vht_pkg.sv */
// Shared types and constants for the visibility history table.
`timescale 1ns / 1ps

package vht_pkg;

   localparam logic [1:0] MODE_UPDATE     = 2'd0;
   localparam logic [1:0] MODE_QUERY      = 2'd1;
   localparam logic [1:0] MODE_INVALIDATE = 2'd2;
   localparam logic [1:0] MODE_CLEAR      = 2'd3;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_LIMIT      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY_THRESHOLD = 1'd1;

   localparam logic [6:0]  CAPACITY_RESET  = 7'd64;
   localparam logic [15:0] THRESHOLD_RESET = 16'd4;
   localparam logic [15:0] RUN_MAX         = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] node_key;
      logic        visible_now;
      logic [31:0] error_bits;
      logic [31:0] distance_bits;
      logic [31:0] frame_number;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        found;
      logic        was_visible_before;
      logic        is_visible;
      logic        is_stable;
      logic [15:0] visible_run;
      logic [15:0] hidden_run;
      logic [31:0] stored_error_bits;
      logic [31:0] stored_distance_bits;
      logic [31:0] last_frame;
   } rsp_type;

   // Per-entry record kept beside the key; the current flag lives apart so
   // that invalidation is a plain write sweep.
   typedef struct packed {
      logic        prev_visible;
      logic [15:0] hidden_run;
      logic [15:0] visible_run;
      logic [31:0] distance_bits;
      logic [31:0] error_bits;
      logic [31:0] frame;
   } rec_type;

   typedef struct packed {
      logic hit;
      logic free;
   } match_flags_type;

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_SCAN,
      ST_SETTLE,
      ST_DECIDE,
      ST_CALC,
      ST_FLAGS,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

/* sv/vht_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module vht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/vht_match.sv */
// Shared key comparator that scans one entry per cycle for a hit and a free slot.
`timescale 1ns / 1ps

module vht_match
   import vht_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             sample,
   input  logic [IDX_W-1:0] sample_idx,
   input  logic             entry_vld,
   input  logic [63:0]      entry_key,
   input  logic [63:0]      search_key,
   output match_flags_type  flags,
   output logic [IDX_W-1:0] hit_idx,
   output logic [IDX_W-1:0] free_idx
);

   logic             hit_ff, hit_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             key_eq;

   assign key_eq = entry_key == search_key;

   // The first hit and the lowest free slot are kept; later ones are ignored.
   always_comb begin
      hit_in      = hit_ff;
      free_in     = free_ff;
      hit_idx_in  = hit_idx_ff;
      free_idx_in = free_idx_ff;
      if (clear) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (sample) begin
         if (entry_vld && key_eq && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = sample_idx;
         end
         if (!entry_vld && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = sample_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign flags.hit  = hit_ff;
   assign flags.free = free_ff;
   assign hit_idx    = hit_idx_ff;
   assign free_idx   = free_idx_ff;

endmodule

/* sv/visibility_history_table_top.sv */
// Visibility history table: keyed records with insert on miss, scanned by one comparator.
`timescale 1ns / 1ps
// Update and query: the comparator walks every entry once, one per cycle; then the states
// ST_SETTLE, ST_DECIDE, ST_CALC (skipped when no entry is reported) and ST_DONE follow,
// the result enters the output register and the next item is taken; a stalled result
// holds the block meanwhile. Invalidate and clear sweep the table one entry per cycle.
// After reset the valid store is wiped entry by entry, during which req_stall is high;
// configuration writes are taken at any time.

module visibility_history_table_top
   import vht_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UW = $clog2(ENTRIES + 1);
   localparam int LW = (UW > 7) ? UW : 7;
   localparam int RW = $bits(rec_type);

   state_type        state_ff, state_in;
   logic [IW-1:0]    cnt_ff, cnt_in;
   logic             samp_ff, samp_in;
   logic [IW-1:0]    samp_idx_ff, samp_idx_in;
   req_type          req_ff, req_in;
   logic [IW-1:0]    slot_ff, slot_in;
   logic             insert_ff, insert_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [6:0]       cap_ff, cap_in;
   logic [15:0]      thr_ff, thr_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             cnt_last;
   logic             accept;
   logic             out_free;
   logic             is_update;
   logic             can_insert;
   logic             go;
   logic [IW-1:0]    slot_sel;

   logic [IW-1:0]    ram_addr;
   logic             vld_we, vld_wd, vld_rd;
   logic             key_we;
   logic [63:0]      key_rd;
   logic             cur_we, cur_wd, cur_rd;
   logic             rec_we;
   rec_type          rec_wd, rec_rd;

   match_flags_type  mflags;
   logic [IW-1:0]    hit_idx, free_idx;

   rec_type          old_rec, new_rec, rep_rec;
   logic             old_cur, rep_cur;

   assign cnt_last  = cnt_ff == IW'(ENTRIES - 1);
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_update = req_ff.mode == MODE_UPDATE;

   // Insert only on a miss, with a free slot and room under the configured limit.
   assign can_insert = is_update && !mflags.hit && mflags.free && (LW'(used_ff) < LW'(cap_ff));
   assign go         = mflags.hit || can_insert;
   assign slot_sel   = mflags.hit ? hit_idx : free_idx;

   vht_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_vld_ram (
      .clock   (clock),
      .wr_en   (vld_we),
      .wr_addr (ram_addr),
      .wr_data (vld_wd),
      .rd_addr (ram_addr),
      .rd_data (vld_rd)
   );

   vht_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (ram_addr),
      .wr_data (req_ff.node_key),
      .rd_addr (ram_addr),
      .rd_data (key_rd)
   );

   vht_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (ram_addr),
      .wr_data (cur_wd),
      .rd_addr (ram_addr),
      .rd_data (cur_rd)
   );

   vht_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (ram_addr),
      .wr_data (rec_wd),
      .rd_addr (ram_addr),
      .rd_data (rec_rd)
   );

   vht_match #(.IDX_W(IW)) u_match (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .sample     (samp_ff),
      .sample_idx (samp_idx_ff),
      .entry_vld  (vld_rd),
      .entry_key  (key_rd),
      .search_key (req_ff.node_key),
      .flags      (mflags),
      .hit_idx    (hit_idx),
      .free_idx   (free_idx)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WIPE: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.mode)
                  MODE_UPDATE, MODE_QUERY: state_in = ST_SCAN;
                  MODE_INVALIDATE:         state_in = ST_FLAGS;
                  default:                 state_in = ST_CLEAR;
               endcase
            end
         end
         ST_SCAN: begin
            if (cnt_last) state_in = ST_SETTLE;
         end
         ST_SETTLE: state_in = ST_DECIDE;
         ST_DECIDE: state_in = go ? ST_CALC : ST_DONE;
         ST_CALC:   state_in = ST_DONE;
         ST_FLAGS: begin
            if (cnt_last) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (cnt_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory controls per state.
   always_comb begin
      ram_addr = cnt_ff;
      vld_we   = 1'b0;
      vld_wd   = 1'b0;
      key_we   = 1'b0;
      cur_we   = 1'b0;
      cur_wd   = 1'b0;
      rec_we   = 1'b0;
      case (state_ff)
         ST_WIPE, ST_CLEAR: begin
            vld_we = 1'b1;
         end
         ST_FLAGS: begin
            cur_we = 1'b1;
         end
         ST_DECIDE: begin
            ram_addr = slot_sel;
         end
         ST_CALC: begin
            ram_addr = slot_ff;
            if (is_update) begin
               cur_we = 1'b1;
               cur_wd = req_ff.visible_now;
               rec_we = 1'b1;
            end
            if (insert_ff) begin
               vld_we = 1'b1;
               vld_wd = 1'b1;
               key_we = 1'b1;
            end
         end
         default: begin
            ram_addr = cnt_ff;
         end
      endcase
   end

   // Record update: a fresh insert starts from an all-zero entry.
   always_comb begin
      old_cur = insert_ff ? 1'b0 : cur_rd;
      old_rec = insert_ff ? '0 : rec_rd;
      new_rec.prev_visible  = old_cur;
      new_rec.error_bits    = req_ff.error_bits;
      new_rec.distance_bits = req_ff.distance_bits;
      new_rec.frame         = req_ff.frame_number;
      if (req_ff.visible_now) begin
         new_rec.visible_run = (old_rec.visible_run == RUN_MAX) ?
                               RUN_MAX : old_rec.visible_run + 16'd1;
         new_rec.hidden_run  = 16'd0;
      end else begin
         new_rec.hidden_run  = (old_rec.hidden_run == RUN_MAX) ?
                               RUN_MAX : old_rec.hidden_run + 16'd1;
         new_rec.visible_run = 16'd0;
      end
      rec_wd  = new_rec;
      rep_rec = is_update ? new_rec : old_rec;
      rep_cur = is_update ? req_ff.visible_now : old_cur;
   end

   // Datapath next values.
   always_comb begin
      cnt_in      = '0;
      samp_in     = state_ff == ST_SCAN;
      samp_idx_in = cnt_ff;
      req_in      = accept ? req_payload : req_ff;
      slot_in     = slot_ff;
      insert_in   = insert_ff;
      used_in     = used_ff;
      res_in      = res_ff;
      cap_in      = cap_ff;
      thr_in      = thr_ff;

      if (state_ff == ST_WIPE || state_ff == ST_SCAN ||
          state_ff == ST_FLAGS || state_ff == ST_CLEAR) begin
         cnt_in = cnt_last ? '0 : cnt_ff + IW'(1);
      end

      if (accept) begin
         res_in = '0;
      end

      if (state_ff == ST_DECIDE) begin
         slot_in   = slot_sel;
         insert_in = can_insert;
      end

      if (state_ff == ST_CLEAR) begin
         used_in = '0;
      end else if (state_ff == ST_CALC && insert_ff) begin
         used_in = used_ff + UW'(1);
      end

      if (state_ff == ST_CALC) begin
         res_in.accepted             = is_update;
         res_in.found                = 1'b1;
         res_in.was_visible_before   = rep_rec.prev_visible;
         res_in.is_visible           = rep_cur;
         res_in.is_stable            = (rep_rec.visible_run >= thr_ff) ||
                                       (rep_rec.hidden_run >= thr_ff);
         res_in.visible_run          = rep_rec.visible_run;
         res_in.hidden_run           = rep_rec.hidden_run;
         res_in.stored_error_bits    = rep_rec.error_bits;
         res_in.stored_distance_bits = rep_rec.distance_bits;
         res_in.last_frame           = rep_rec.frame;
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_CAPACITY_LIMIT:      cap_in = csr_wdata[6:0];
            CSR_STABILITY_THRESHOLD: thr_in = csr_wdata[15:0];
            default: begin
               cap_in = cap_ff;
            end
         endcase
      end
   end

   // Output register: a finished transaction waits here while the next one starts.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         cnt_ff       <= '0;
         samp_ff      <= 1'b0;
         insert_ff    <= 1'b0;
         used_ff      <= '0;
         cap_ff       <= CAPACITY_RESET;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         samp_ff      <= samp_in;
         insert_ff    <= insert_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_idx_ff <= samp_idx_in;
      req_ff      <= req_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(ENTRIES))
      else $error("entry count exceeds table depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion state");

   a_insert_on_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && insert_ff) |-> (!mflags.hit && mflags.free))
      else $error("insert without a miss and a free slot");

endmodule
